// ===== rtl/mbed_pkg.sv =====
// Shared types and constants for the mouse button event decoder.
`default_nettype none
package mbed_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int BTN_W           = 5;
    localparam int CFG_W           = 13;
    localparam int MOVE_W          = 16;
    localparam int TIME_W          = 32;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd500;

    typedef logic [BTN_W-1:0]         t_btn;
    typedef logic signed [MOVE_W-1:0] t_move;
    typedef logic [TIME_W-1:0]        t_time;
    typedef logic [CFG_W-1:0]         t_cfg;

    // one poll word as taken from the input channel
    typedef struct packed {
        logic  active;
        t_btn  button_levels;
        t_move move_x;
        t_move move_y;
        t_move wheel;
        t_time now_ms;
    } t_poll;

    // one result word
    typedef struct packed {
        logic  moved;
        logic  any_press;
        t_btn  press_mask;
        t_btn  double_mask;
        t_btn  release_mask;
        t_btn  held_mask;
        t_move out_x;
        t_move out_y;
        t_move out_wheel;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/mouse_button_event_decoder.sv =====
// Mouse button event decoder: top level with config and result registers.
// Words pass the input register and decode logic into the result register.
// Throughput: one word per cycle while the output is not stalled; set by
//   the single pass from input register via decode logic to result register.
// Reset (synchronous, active low): empties both registers, clears the button
//   and click tracking state and loads the 500 ms double-click interval.
`default_nettype none
module mouse_button_event_decoder #(
    parameter int NUM_BUTTONS = mbed_pkg::NUM_BUTTONS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mbed_pkg::CFG_W-1:0]       i_cfg_data,
    // poll words
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_active,
    input  wire [mbed_pkg::BTN_W-1:0]       i_button_levels,
    input  wire signed [mbed_pkg::MOVE_W-1:0] i_move_x,
    input  wire signed [mbed_pkg::MOVE_W-1:0] i_move_y,
    input  wire signed [mbed_pkg::MOVE_W-1:0] i_wheel,
    input  wire [mbed_pkg::TIME_W-1:0]      i_now_ms,
    // result words
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_moved,
    output logic                            o_any_press,
    output logic [mbed_pkg::BTN_W-1:0]      o_press_mask,
    output logic [mbed_pkg::BTN_W-1:0]      o_double_mask,
    output logic [mbed_pkg::BTN_W-1:0]      o_release_mask,
    output logic [mbed_pkg::BTN_W-1:0]      o_held_mask,
    output logic signed [mbed_pkg::MOVE_W-1:0] o_out_x,
    output logic signed [mbed_pkg::MOVE_W-1:0] o_out_y,
    output logic signed [mbed_pkg::MOVE_W-1:0] o_out_wheel
);

    mbed_pkg::t_cfg    r_cfg;
    mbed_pkg::t_poll   w_in_word;
    mbed_pkg::t_poll   w_s1_word;
    logic              w_s1_valid;
    logic              w_fire;
    mbed_pkg::t_result w_result;
    mbed_pkg::t_result r_out;
    logic              r_out_valid;

    // double-click interval register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mbed_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // pack the incoming word
    always_comb begin
        w_in_word.active        = i_active;
        w_in_word.button_levels = i_button_levels;
        w_in_word.move_x        = i_move_x;
        w_in_word.move_y        = i_move_y;
        w_in_word.wheel         = i_wheel;
        w_in_word.now_ms        = i_now_ms;
    end

    // the held word moves on when the result register is free
    assign w_fire = w_s1_valid && (!r_out_valid || !i_out_stall);

    mbed_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (w_in_word),
        .i_take  (w_fire),
        .o_valid (w_s1_valid),
        .o_data  (w_s1_word)
    );

    mbed_decode #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_poll   (w_s1_word),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_moved        = r_out.moved;
    assign o_any_press    = r_out.any_press;
    assign o_press_mask   = r_out.press_mask;
    assign o_double_mask  = r_out.double_mask;
    assign o_release_mask = r_out.release_mask;
    assign o_held_mask    = r_out.held_mask;
    assign o_out_x        = r_out.out_x;
    assign o_out_y        = r_out.out_y;
    assign o_out_wheel    = r_out.out_wheel;

endmodule
`default_nettype wire

// ===== rtl/mbed_in_reg.sv =====
// Input register stage holding one poll word.
`default_nettype none
module mbed_in_reg (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  mbed_pkg::t_poll i_data,
    input  wire             i_take,
    output logic            o_valid,
    output mbed_pkg::t_poll o_data
);

    logic            r_valid;
    mbed_pkg::t_poll r_data;
    logic            w_load;

    // free when empty or when the held word moves on this cycle
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/mbed_decode.sv =====
// Button edge and double-click decode with its tracking state.
`default_nettype none
module mbed_decode #(
    parameter int NUM_BUTTONS = mbed_pkg::NUM_BUTTONS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_fire,
    input  mbed_pkg::t_poll   i_poll,
    input  mbed_pkg::t_cfg    i_cfg,
    output mbed_pkg::t_result o_result
);

    localparam int NB_USED = (NUM_BUTTONS < mbed_pkg::BTN_W) ? NUM_BUTTONS
                                                              : mbed_pkg::BTN_W;

    mbed_pkg::t_btn  r_prev, n_prev;
    mbed_pkg::t_time r_last, n_last;
    mbed_pkg::t_time r_dtime, n_dtime;
    logic            r_recent, n_recent;
    logic            r_still, n_still;

    mbed_pkg::t_btn  w_levels;
    mbed_pkg::t_time w_dt_last;
    mbed_pkg::t_time w_dt_dbl;
    mbed_pkg::t_time w_cfg32;
    logic            w_lt_first;
    logic            w_gt_dbl;
    logic            w_moved;

    // both time gaps against the registered state, wrapping modulo 2^32
    assign w_cfg32    = {{(mbed_pkg::TIME_W-mbed_pkg::CFG_W){1'b0}}, i_cfg};
    assign w_dt_last  = i_poll.now_ms - r_last;
    assign w_dt_dbl   = i_poll.now_ms - r_dtime;
    assign w_lt_first = w_dt_last < w_cfg32;
    assign w_gt_dbl   = w_dt_dbl > w_cfg32;
    assign w_moved    = (i_poll.move_x != '0) || (i_poll.move_y != '0);

    always_comb begin
        for (int k = 0; k < mbed_pkg::BTN_W; k++) begin
            w_levels[k] = (k < NB_USED) ? i_poll.button_levels[k] : 1'b0;
        end
    end

    // buttons in order; after the first press the press gap is zero and
    // the double-click gap is zero once a double click is taken here
    always_comb begin
        logic            v_still;
        logic            v_recent;
        logic            v_l_now;
        logic            v_d_now;
        logic            v_in_gap;
        mbed_pkg::t_btn  v_press;
        mbed_pkg::t_btn  v_dbl;
        mbed_pkg::t_btn  v_rel;
        mbed_pkg::t_btn  v_held;

        v_still  = r_still && !w_moved;
        v_recent = r_recent;
        v_l_now  = 1'b0;
        v_d_now  = 1'b0;
        v_in_gap = 1'b0;
        v_press  = '0;
        v_dbl    = '0;
        v_rel    = '0;
        v_held   = '0;

        for (int i = 0; i < NB_USED; i++) begin
            if (w_levels[i] && !r_prev[i]) begin
                v_press[i] = 1'b1;
                v_in_gap   = v_l_now ? (i_cfg != '0) : w_lt_first;
                if (v_in_gap) begin
                    if (!w_moved && v_still) begin
                        if (v_recent && !v_d_now && w_gt_dbl) begin
                            v_recent = 1'b0;
                        end
                        if (!v_recent) begin
                            v_recent = 1'b1;
                            v_d_now  = 1'b1;
                            v_dbl[i] = 1'b1;
                        end
                    end
                end else begin
                    v_recent = 1'b0;
                end
                v_l_now = 1'b1;
                v_still = 1'b1;
            end
            if (!w_levels[i] && r_prev[i]) begin
                v_rel[i] = 1'b1;
            end
            if (w_levels[i] && r_prev[i]) begin
                v_held[i] = 1'b1;
            end
        end

        // state moves only on an active word that is taken
        if (i_fire && i_poll.active) begin
            n_prev   = w_levels;
            n_last   = v_l_now ? i_poll.now_ms : r_last;
            n_dtime  = v_d_now ? i_poll.now_ms : r_dtime;
            n_recent = v_recent;
            n_still  = v_still;
        end else begin
            n_prev   = r_prev;
            n_last   = r_last;
            n_dtime  = r_dtime;
            n_recent = r_recent;
            n_still  = r_still;
        end

        // inactive poll gives an all-zero result
        if (i_poll.active) begin
            o_result.moved        = w_moved;
            o_result.any_press    = v_press != '0;
            o_result.press_mask   = v_press;
            o_result.double_mask  = v_dbl;
            o_result.release_mask = v_rel;
            o_result.held_mask    = v_held;
            o_result.out_x        = i_poll.move_x;
            o_result.out_y        = i_poll.move_y;
            o_result.out_wheel    = i_poll.wheel;
        end else begin
            o_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_last   <= '0;
            r_dtime  <= '0;
            r_recent <= 1'b0;
            r_still  <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_last   <= n_last;
            r_dtime  <= n_dtime;
            r_recent <= n_recent;
            r_still  <= n_still;
        end
    end

endmodule
`default_nettype wire
